>>> src/hhlp_pkg.sv
// Package for the HTTP header line parser.
// Item and result structs, parser state, status and phase codes, token character function.
// No dependencies.
package hhlp_pkg;

    localparam int MaxLineDefault = 4096;
    localparam int PosWidth       = 12;

    localparam logic [1:0] PH_NAME  = 2'd0;
    localparam logic [1:0] PH_SEP   = 2'd1;
    localparam logic [1:0] PH_VALUE = 2'd2;
    localparam logic [1:0] PH_CR    = 2'd3;

    localparam logic [2:0] ST_BUSY    = 3'd0;
    localparam logic [2:0] ST_DONE    = 3'd1;
    localparam logic [2:0] ST_BADNAME = 3'd2;
    localparam logic [2:0] ST_BARECR  = 3'd3;
    localparam logic [2:0] ST_TRUNC   = 3'd4;
    localparam logic [2:0] ST_LONG    = 3'd5;

    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       stream_end;
    } t_in_item;

    typedef struct packed {
        logic [2:0]          status;
        logic [PosWidth-1:0] name_length;
        logic [PosWidth-1:0] value_offset;
        logic [PosWidth-1:0] value_length;
    } t_out_item;

    typedef struct packed {
        logic [1:0]          phase;
        logic [PosWidth-1:0] line_position;
        logic [PosWidth-1:0] name_count;
        logic [PosWidth-1:0] value_start;
        logic [PosWidth-1:0] value_count;
    } t_state;

    // RFC 7230 tchar
    function automatic logic is_token(input logic [7:0] c);
        logic ok;
        ok = 1'b0;
        if (c inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A]}) begin
            ok = 1'b1;
        end
        if (c inside {8'h21, 8'h23, 8'h24, 8'h25, 8'h26, 8'h27, 8'h2A, 8'h2B,
                      8'h2D, 8'h2E, 8'h5E, 8'h5F, 8'h60, 8'h7C, 8'h7E}) begin
            ok = 1'b1;
        end
        return ok;
    endfunction

endpackage

>>> src/hhlp_step.sv
// Per-byte step logic of the header line parser: next state and result.
// Depends on hhlp_pkg.
module hhlp_step #(
    parameter int MAX_LINE = hhlp_pkg::MaxLineDefault
) (
    input  hhlp_pkg::t_state    i_state,
    input  hhlp_pkg::t_in_item  i_item,
    output hhlp_pkg::t_state    o_next_state,
    output hhlp_pkg::t_out_item o_result
);
    import hhlp_pkg::*;

    localparam int LineLimit = (MAX_LINE < 4096) ? MAX_LINE : 4096;

    logic [7:0]          c;
    logic [PosWidth-1:0] p;
    logic [PosWidth:0]   p_inc;
    logic [2:0]          status;
    t_state              st;

    assign c     = i_item.data_byte;
    assign p     = i_state.line_position;
    assign p_inc = {1'b0, p} + {{PosWidth{1'b0}}, 1'b1};

    always_comb begin
        st     = i_state;
        status = ST_BUSY;
        if (i_item.stream_end) begin
            status = ST_TRUNC;
        end else begin
            case (i_state.phase)
                PH_NAME: begin
                    if (is_token(c)) begin
                        st.name_count = i_state.name_count + {{(PosWidth-1){1'b0}}, 1'b1};
                    end else if (c == CH_COLON) begin
                        st.phase = PH_SEP;
                    end else begin
                        status = ST_BADNAME;
                    end
                end
                PH_SEP: begin
                    if (c == CH_SP || c == CH_TAB) begin
                        st.phase = PH_SEP;
                    end else if (c == CH_LF) begin
                        st.value_start = p;
                        st.value_count = '0;
                        status         = ST_DONE;
                    end else if (c == CH_CR) begin
                        st.value_start = p;
                        st.value_count = '0;
                        st.phase       = PH_CR;
                    end else begin
                        st.value_start = p;
                        st.value_count = {{(PosWidth-1){1'b0}}, 1'b1};
                        st.phase       = PH_VALUE;
                    end
                end
                PH_VALUE: begin
                    if (c == CH_LF) begin
                        status = ST_DONE;
                    end else if (c == CH_CR) begin
                        st.phase = PH_CR;
                    end else begin
                        st.value_count = i_state.value_count + {{(PosWidth-1){1'b0}}, 1'b1};
                    end
                end
                default: begin
                    status = (c == CH_LF) ? ST_DONE : ST_BARECR;
                end
            endcase
            if (status == ST_BUSY) begin
                if (p_inc >= (PosWidth+1)'(LineLimit)) begin
                    status = ST_LONG;
                end else begin
                    st.line_position = p_inc[PosWidth-1:0];
                end
            end
        end
    end

    always_comb begin
        o_result        = '0;
        o_result.status = status;
        if (status == ST_DONE) begin
            o_result.name_length  = st.name_count;
            o_result.value_offset = st.value_start;
            o_result.value_length = st.value_count;
        end
        // rearm after done or any error
        o_next_state = (status == ST_BUSY) ? st : '0;
    end

endmodule

>>> src/http_header_line_parser_core.sv
// HTTP header line parser, top level: input register, parser state, result register.
// Depends on hhlp_pkg and hhlp_step.
//
// Use: feed one byte of a header line per input item (data_byte), or an item
// with stream_end set when the source runs dry. Every item gives exactly one
// result item: status in progress, done, bad name character, CR without LF,
// truncated or line too long. On done the result also holds name length,
// value offset from the line start and value length; otherwise those are 0.
// After done or any error the parser rearms for the next line.
// Both channels are valid/ready. An item is registered on acceptance, runs
// through the combinational step logic and lands in the result register,
// which drives o_valid; while the receiver does not stall, one item per
// cycle is sustained. The parser state
// updates as an item moves into the result register, so consecutive bytes
// chain without bubbles.
// If the receiver stalls, the result register and the input register both
// hold, and o_ready drops once both are full; nothing is lost.
// Reset (synchronous, active low) empties both registers and returns the
// parser to the start of a line.
module http_header_line_parser_core #(
    parameter int MAX_LINE = hhlp_pkg::MaxLineDefault
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  hhlp_pkg::t_in_item  i_item,
    output logic                o_valid,
    input  logic                i_ready,
    output hhlp_pkg::t_out_item o_result
);
    import hhlp_pkg::*;

    localparam int LineLimit = (MAX_LINE < 4096) ? MAX_LINE : 4096;

    logic      r_in_vld;
    t_in_item  r_in_item;
    logic      r_out_vld;
    t_out_item r_out_item;
    t_state    r_state;
    t_state    n_state;
    t_out_item n_out_item;
    logic      advance;

    hhlp_step #(
        .MAX_LINE(MAX_LINE)
    ) u_step (
        .i_state     (r_state),
        .i_item      (r_in_item),
        .o_next_state(n_state),
        .o_result    (n_out_item)
    );

    assign advance  = r_in_vld && (!r_out_vld || i_ready);
    assign o_ready  = !r_in_vld || advance;
    assign o_valid  = r_out_vld;
    assign o_result = r_out_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_state   <= '0;
        end else begin
            if (o_ready) begin
                r_in_vld <= i_valid;
            end
            if (advance) begin
                r_out_vld <= 1'b1;
                r_state   <= n_state;
            end else if (i_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_item <= i_item;
        end
        if (advance) begin
            r_out_item <= n_out_item;
        end
    end

    // a finished line or error leaves the parser at line start
    a_rearm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && n_out_item.status != ST_BUSY) |=> (r_state == '0))
        else $error("parser not rearmed after line end");

    a_pos_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_state.line_position} < (PosWidth+1)'(LineLimit)))
        else $error("line position beyond limit");

    a_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out_item.status != ST_DONE) |->
        (r_out_item.name_length == '0 && r_out_item.value_offset == '0 &&
         r_out_item.value_length == '0))
        else $error("length fields set on non-done result");

    a_offset_after_name: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out_item.status == ST_DONE) |->
        (r_out_item.value_offset > r_out_item.name_length))
        else $error("value offset not past the colon");

    a_stall_on_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_vld && r_out_vld && !i_ready) |-> !o_ready)
        else $error("input taken with both registers full");

endmodule
